// ----- design/i2da_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types, ASCII codes and decimal weight tables for the signed 32-bit
// integer to decimal text converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

    // ASCII codes
    localparam logic [6:0] ASCII_MINUS = 7'd45;
    localparam logic [6:0] ASCII_ZERO  = 7'd48;

    // number of decimal positions in a 32-bit magnitude
    localparam int NUM_POS = 10;

    // weights wide enough for 9 * 10^9
    localparam int WEIGHT_W = 34;

    localparam logic [WEIGHT_W-1:0] POW10 [NUM_POS] = '{
        34'd1,
        34'd10,
        34'd100,
        34'd1000,
        34'd10000,
        34'd100000,
        34'd1000000,
        34'd10000000,
        34'd100000000,
        34'd1000000000
    };

    // one queued number: sign, magnitude, index of its top decimal position
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
        logic [3:0]  pos;
    } t_item;

    // digit times decimal weight; d is a constant at every call site
    function automatic logic [WEIGHT_W-1:0] f_mult(input logic [3:0] k, input logic [3:0] d);
        logic [WEIGHT_W-1:0] w;
        w = (k < 4'(NUM_POS)) ? POW10[k] : '0;
        return WEIGHT_W'(w * {30'd0, d});
    endfunction

endpackage

// ----- design/int32_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready, i_value) takes one two's complement
//   number per transfer. Output channel (o_valid / i_ready) returns its text
//   one character per transfer on o_text_char: '-' first for a negative
//   value, then the digits with leading zeros dropped ("0" for zero).
//   o_last_char marks the final character of each number.
//   A number passes the front input register and the queue before its first
//   character is loaded into the output register. Throughput: one character
//   per cycle unless the receiver stalls, 1 to 11 characters per number
//   (11 for -2147483648), from the digit unit behind the output register.
//   The front keeps taking numbers into a two-entry queue while the back end
//   emits, so a new number is accepted while earlier ones are still printing.
//   When the receiver stalls, the output register holds its character, the
//   queue and the front input register fill, after which o_ready drops.
//   Synchronous active-low reset empties the pipeline; no other state.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_text_char,
    output logic        o_last_char
);
    import i2da_pkg::*;

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_item w_front_item;
    t_item w_head;

    i2da_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_push  (w_push),
        .o_item  (w_front_item),
        .i_full  (w_full)
    );

    i2da_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty)
    );

    i2da_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule

// ----- design/i2da_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_queue
// Two-entry queue that decouples the classifying front from the character
// emitting back end.
// ----------------------------------------------------------------------------
module i2da_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  i2da_pkg::t_item i_data,
    output logic           o_full,
    input  logic           i_pop,
    output i2da_pkg::t_item o_data,
    output logic           o_empty
);
    import i2da_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- design/i2da_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_front
// Takes in signed values, registers sign and magnitude, then finds the top
// decimal position of the magnitude and pushes the item to the queue.
// ----------------------------------------------------------------------------
module i2da_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [31:0]     i_value,
    output logic            o_push,
    output i2da_pkg::t_item o_item,
    input  logic            i_full
);
    import i2da_pkg::*;

    logic        r_valid;
    logic        r_neg;
    logic [31:0] r_mag;
    logic [NUM_POS-1:1] w_ge;

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;

    // input register: sign and magnitude (most negative stays 2^31 unsigned)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_neg <= i_value[31];
            r_mag <= i_value[31] ? (32'd0 - i_value) : i_value;
        end
    end

    // top position = number of weights 10..10^9 not above the magnitude
    always_comb begin
        for (int k = 1; k < NUM_POS; k++) begin
            w_ge[k] = ({2'b00, r_mag} >= POW10[k]);
        end
        o_item.neg = r_neg;
        o_item.mag = r_mag;
        o_item.pos = 4'($countones(w_ge));
    end

endmodule

// ----- design/i2da_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_back
// Emits one character per unstalled cycle: the minus sign if any, then one
// decimal digit per position, top position down, into an output register.
// ----------------------------------------------------------------------------
module i2da_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  i2da_pkg::t_item i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [6:0]      o_text_char,
    output logic            o_last_char
);
    import i2da_pkg::*;

    logic        r_busy;
    logic        n_busy;
    t_item       r_item;
    t_item       n_item;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [6:0]  r_char;
    logic [6:0]  n_char;
    logic        r_last;
    logic        n_last;

    logic                w_adv;
    logic                w_have;
    t_item               w_cur;
    logic [WEIGHT_W-1:0] w_thr [NUM_POS];
    logic [NUM_POS-1:1]  w_ge;
    logic [3:0]          w_digit;
    logic [WEIGHT_W-1:0] w_sub;

    assign o_valid     = r_out_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

    // digit step; a new item is taken straight from the queue head
    always_comb begin
        w_adv  = !r_out_valid || i_ready;
        w_have = r_busy || !i_empty;
        w_cur  = r_busy ? r_item : i_head;

        // compare the remainder against d * 10^pos in parallel
        w_thr[0] = '0;
        for (int d = 1; d < NUM_POS; d++) begin
            w_thr[d] = f_mult(w_cur.pos, 4'(d));
            w_ge[d]  = ({2'b00, w_cur.mag} >= w_thr[d]);
        end
        w_digit = 4'($countones(w_ge));
        w_sub   = w_thr[w_digit];

        o_pop       = w_adv && !r_busy && !i_empty;
        n_busy      = r_busy;
        n_item      = r_item;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;

        if (w_adv && w_have) begin
            n_out_valid = 1'b1;
            if (w_cur.neg) begin
                n_char     = ASCII_MINUS;
                n_last     = 1'b0;
                n_item     = w_cur;
                n_item.neg = 1'b0;
                n_busy     = 1'b1;
            end else begin
                n_char     = ASCII_ZERO + {3'b000, w_digit};
                n_last     = (w_cur.pos == 4'd0);
                n_item.neg = 1'b0;
                n_item.mag = w_cur.mag - w_sub[31:0];
                n_item.pos = w_cur.pos - 4'd1;
                n_busy     = (w_cur.pos != 4'd0);
            end
        end else if (w_adv) begin
            n_out_valid = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule
